>>> hdl/chkt_pkg.sv
// chkt_pkg: shared types and constants for the coalesced hash key table
// depends on nothing; used by the interfaces and the top level
`default_nettype none

package chkt_pkg;

    localparam int KEY_W    = 32;
    localparam int CFG_W    = 11;
    localparam int SLOT_W   = 10;
    localparam int STATUS_W = 3;
    localparam int KIND_W   = 2;

    localparam logic [KEY_W-1:0] KEY_EMPTY = '1;
    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1021;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP = 2'd0,
        KIND_INSERT = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_RESERVED  = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DIV,
        S_LK_RD,
        S_LK_CHK,
        S_PR_RD,
        S_PR_CHK,
        S_INS_WR,
        S_TL_RD,
        S_TL_CHK,
        S_LINK,
        S_RM_UNLINK,
        S_RM_EMPTY,
        S_CLR,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> hdl/chkt_req_if.sv
// chkt_req_if: request channel (operation kind and key) with valid/ready
// depends on chkt_pkg
`default_nettype none

interface chkt_req_if
    import chkt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

`default_nettype wire

>>> hdl/chkt_rsp_if.sv
// chkt_rsp_if: response channel (status and slot index) with valid/ready
// depends on chkt_pkg
`default_nettype none

interface chkt_rsp_if
    import chkt_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

`default_nettype wire

>>> hdl/coalesced_hash_key_table.sv
// coalesced_hash_key_table: slot table of 32-bit keys with doubly linked chains
// depends on chkt_pkg, chkt_req_if, chkt_rsp_if
//
//   channel | direction | payload            | handshake
//   req     | in        | kind, key          | valid/ready
//   rsp     | out       | status, slot_index | valid/ready
//   cfg     | in        | table_size         | cfg_wr_en only
//
// one item at a time; a key first runs a bit-serial remainder, then each
// probe or chain step takes a read state and a check state over the slot memories.
// lookup ends with the chain walk; remove adds an unlink and an empty state;
// insert probes for a free slot and writes it, then reads the home chain to its
// tail and writes the link when the new slot is chained behind its home slot.
// clear and the post-reset clearing pass each sweep all MAX_SLOTS slots; req is
// not ready during the pass. one finished response may wait in the output
// register while the next request is taken.
`default_nettype none

module coalesced_hash_key_table
    import chkt_pkg::*;
#(
    parameter int MAX_SLOTS = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [CFG_W-1:0] cfg_wr_data,
    chkt_req_if.sink              req,
    chkt_rsp_if.source            rsp
);

    localparam int SW = $clog2(MAX_SLOTS);
    localparam int LW = $clog2(MAX_SLOTS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(MAX_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_SLOTS - 1);

    // slot memories
    logic [KEY_W-1:0] key_mem  [MAX_SLOTS];
    logic [LW-1:0]    next_mem [MAX_SLOTS];
    logic [LW-1:0]    prev_mem [MAX_SLOTS];

    logic [KEY_W-1:0] key_rd;
    logic [LW-1:0]    next_rd;
    logic [LW-1:0]    prev_rd;
    logic [SW-1:0]    rd_addr;

    logic             key_we, next_we, prev_we;
    logic [SW-1:0]    key_wa, next_wa, prev_wa;
    logic [KEY_W-1:0] key_wd;
    logic [LW-1:0]    next_wd, prev_wd;

    state_t           state_reg, state_next;
    kind_t            kind_reg, kind_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [KEY_W-1:0] div_reg, div_next;
    logic [4:0]       bit_reg, bit_next;
    logic [LW-1:0]    eff_reg, eff_next;
    logic [LW-1:0]    home_reg, home_next;
    logic [LW-1:0]    cur_reg, cur_next;
    logic [LW-1:0]    steps_reg, steps_next;
    logic [LW-1:0]    n_reg, n_next;
    logic [LW-1:0]    p_reg, p_next;
    logic [SW-1:0]    sweep_reg, sweep_next;
    status_t          status_reg, status_next;
    logic [LW-1:0]    slot_reg, slot_next;
    logic [CFG_W-1:0] size_reg;

    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [SLOT_W-1:0]   out_slot_reg, out_slot_next;

    logic [LW:0]      rem_shift;
    logic [LW-1:0]    eff_size;
    logic [LW-1:0]    cur_inc;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= CFG_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            size_reg <= cfg_wr_data;
        end
    end

    // clamp the configured size into the usable range
    always_comb
    begin
        if (size_reg < CFG_W'(2))
        begin
            eff_size = LW'(2);
        end
        else if (32'(size_reg) > 32'(MAX_SLOTS))
        begin
            eff_size = NULL_LINK;
        end
        else
        begin
            eff_size = LW'(size_reg);
        end
    end

    // memory ports: one read address, one write port per array
    assign rd_addr = cur_reg[SW-1:0];

    always_ff @(posedge clk)
    begin
        key_rd  <= key_mem[rd_addr];
        next_rd <= next_mem[rd_addr];
        prev_rd <= prev_mem[rd_addr];
        if (key_we)
        begin
            key_mem[key_wa] <= key_wd;
        end
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        div_reg        <= div_next;
        bit_reg        <= bit_next;
        eff_reg        <= eff_next;
        home_reg       <= home_next;
        cur_reg        <= cur_next;
        steps_reg      <= steps_next;
        n_reg          <= n_next;
        p_reg          <= p_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    // shared remainder step and probe increment
    assign rem_shift = {cur_reg, div_reg[KEY_W-1]};
    assign cur_inc   = (cur_reg + LW'(1) == eff_reg) ? '0 : cur_reg + LW'(1);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        div_next        = div_reg;
        bit_next        = bit_reg;
        eff_next        = eff_reg;
        home_next       = home_reg;
        cur_next        = cur_reg;
        steps_next      = steps_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        sweep_next      = sweep_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;

        key_we  = 1'b0;
        next_we = 1'b0;
        prev_we = 1'b0;
        key_wa  = cur_reg[SW-1:0];
        next_wa = cur_reg[SW-1:0];
        prev_wa = cur_reg[SW-1:0];
        key_wd  = KEY_EMPTY;
        next_wd = NULL_LINK;
        prev_wd = NULL_LINK;

        case (state_reg)
            S_INIT, S_CLR:
            begin
                key_we  = 1'b1;
                next_we = 1'b1;
                prev_we = 1'b1;
                key_wa  = sweep_reg;
                next_wa = sweep_reg;
                prev_wa = sweep_reg;
                sweep_next = sweep_reg + SW'(1);
                if (sweep_reg == LAST_SLOT)
                begin
                    sweep_next  = '0;
                    status_next = ST_OK;
                    slot_next   = '0;
                    state_next  = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next  = kind_t'(req.kind);
                    key_next   = req.key;
                    div_next   = req.key;
                    bit_next   = '0;
                    eff_next   = eff_size;
                    cur_next   = '0;
                    steps_next = '0;
                    slot_next  = '0;
                    if (kind_t'(req.kind) == KIND_CLEAR)
                    begin
                        sweep_next = '0;
                        state_next = S_CLR;
                    end
                    else if (req.key == KEY_EMPTY)
                    begin
                        status_next = ST_RESERVED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end

            // one remainder bit per cycle
            S_DIV:
            begin
                div_next = {div_reg[KEY_W-2:0], 1'b0};
                bit_next = bit_reg + 5'd1;
                if (rem_shift >= {1'b0, eff_reg})
                begin
                    cur_next = LW'(rem_shift - {1'b0, eff_reg});
                end
                else
                begin
                    cur_next = LW'(rem_shift);
                end
                if (bit_reg == 5'd31)
                begin
                    home_next  = cur_next;
                    state_next = (kind_reg == KIND_INSERT) ? S_PR_RD : S_LK_RD;
                end
            end

            // chain walk for lookup and remove
            S_LK_RD:
            begin
                if (steps_reg >= eff_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_LK_CHK;
                end
            end

            S_LK_CHK:
            begin
                if (key_rd == key_reg)
                begin
                    slot_next = cur_reg;
                    if (kind_reg == KIND_LOOKUP)
                    begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        n_next     = next_rd;
                        p_next     = prev_rd;
                        state_next = S_RM_UNLINK;
                    end
                end
                else if (next_rd >= eff_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = next_rd;
                    steps_next = steps_reg + LW'(1);
                    state_next = S_LK_RD;
                end
            end

            // linear probe for insert
            S_PR_RD:
            begin
                if (steps_reg >= eff_reg)
                begin
                    status_next = ST_FULL;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_PR_CHK;
                end
            end

            S_PR_CHK:
            begin
                if (key_rd == KEY_EMPTY)
                begin
                    state_next = S_INS_WR;
                end
                else if (key_rd == key_reg)
                begin
                    status_next = ST_DUPLICATE;
                    slot_next   = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    cur_next   = cur_inc;
                    steps_next = steps_reg + LW'(1);
                    state_next = S_PR_RD;
                end
            end

            // fill the slot, then, if it is not the home slot, find the home chain's tail
            S_INS_WR:
            begin
                key_we      = 1'b1;
                next_we     = 1'b1;
                prev_we     = 1'b1;
                key_wd      = key_reg;
                slot_next   = cur_reg;
                status_next = ST_OK;
                if (cur_reg == home_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    n_next     = cur_reg;
                    cur_next   = home_reg;
                    steps_next = '0;
                    state_next = S_TL_RD;
                end
            end

            S_TL_RD:
            begin
                state_next = (steps_reg >= eff_reg) ? S_LINK : S_TL_CHK;
            end

            S_TL_CHK:
            begin
                if (next_rd >= eff_reg)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    cur_next   = next_rd;
                    steps_next = steps_reg + LW'(1);
                    state_next = S_TL_RD;
                end
            end

            S_LINK:
            begin
                next_we     = 1'b1;
                next_wd     = n_reg;
                prev_we     = 1'b1;
                prev_wa     = n_reg[SW-1:0];
                prev_wd     = cur_reg;
                slot_next   = n_reg;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            // splice neighbors around the removed slot
            S_RM_UNLINK:
            begin
                prev_we    = (n_reg < eff_reg);
                prev_wa    = n_reg[SW-1:0];
                prev_wd    = p_reg;
                next_we    = (p_reg < eff_reg);
                next_wa    = p_reg[SW-1:0];
                next_wd    = n_reg;
                state_next = S_RM_EMPTY;
            end

            S_RM_EMPTY:
            begin
                key_we      = 1'b1;
                next_we     = 1'b1;
                prev_we     = 1'b1;
                status_next = ST_OK;
                state_next  = S_DONE;
            end

            // hand the result to the output register
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_slot_next   = (status_reg == ST_OK) ? SLOT_W'(slot_reg) : '0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot_index = out_slot_reg;

`ifndef SYNTHESIS
    // a failed operation never reports a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.status != ST_OK) |-> (rsp.slot_index == '0))
        else $error("nonzero slot on failed status");

    // every memory access of a walk stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LK_CHK || state_reg == S_PR_CHK || state_reg == S_TL_CHK)
        |-> (cur_reg < eff_reg))
        else $error("walk address beyond table size");

    // an accepted request starts work on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> (state_reg != S_IDLE))
        else $error("accepted request dropped");

    // a waiting response is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
        else $error("pending response lost");
`endif

endmodule

`default_nettype wire

>>> tb/coalesced_hash_key_table_tb.sv
// coalesced_hash_key_table_tb: random and directed test of the hash key table
// depends on chkt_pkg, chkt_req_if, chkt_rsp_if and coalesced_hash_key_table
`default_nettype none

module coalesced_hash_key_table_tb;
    import chkt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 1024;
    localparam logic [10:0] NULL_LNK = 11'd1024;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        kind_t            kind;
        logic [KEY_W-1:0] key;
    } op_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } answer_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    chkt_req_if req_ch ();
    chkt_rsp_if rsp_ch ();

    coalesced_hash_key_table #(.MAX_SLOTS(NSLOT)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch.sink),
        .rsp         (rsp_ch.source)
    );

    // shadow table
    logic [31:0] sh_key  [NSLOT];
    logic [10:0] sh_next [NSLOT];
    logic [10:0] sh_prev [NSLOT];
    logic [10:0] sh_size;

    op_t     pending_ops[$];
    answer_t answers_due[$];
    int      failures;
    int      cycles;
    int      accepted;
    int      checked;
    bit      calm;       // no idling in the last part
    int      src_gap;
    int      snk_gap;
    logic [31:0] used_keys[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int eff_size();
        if (sh_size < 2) return 2;
        if (sh_size > NSLOT) return NSLOT;
        return sh_size;
    endfunction

    function automatic void wipe_table();
        for (int i = 0; i < NSLOT; i++)
        begin
            sh_key[i]  = KEY_EMPTY;
            sh_next[i] = NULL_LNK;
            sh_prev[i] = NULL_LNK;
        end
    endfunction

    function automatic bit chain_find(logic [31:0] k, int sz, output int where);
        int idx;
        idx = k % sz;
        where = 0;
        for (int s = 0; s < sz; s++)
        begin
            if (sh_key[idx] == k)
            begin
                where = idx;
                return 1'b1;
            end
            idx = sh_next[idx];
            if (idx >= sz) return 1'b0;
        end
        return 1'b0;
    endfunction

    // apply one operation to the shadow table and return its answer
    function automatic answer_t table_apply(op_t op);
        answer_t a;
        int sz, where, home, idx, tail, n;
        bit hit;
        sz = eff_size();
        a.status = ST_OK;
        where = 0;
        if (op.kind == KIND_CLEAR)
            wipe_table();
        else if (op.key == KEY_EMPTY)
            a.status = ST_RESERVED;
        else if (op.kind == KIND_LOOKUP)
            a.status = chain_find(op.key, sz, where) ? ST_OK : ST_NOT_FOUND;
        else if (op.kind == KIND_INSERT)
        begin
            home = op.key % sz;
            hit = 1'b0;
            idx = home;
            for (int i = 0; i < sz; i++)
            begin
                idx = (home + i) % sz;
                if (sh_key[idx] == KEY_EMPTY)
                begin
                    hit = 1'b1;
                    break;
                end
                if (sh_key[idx] == op.key)
                begin
                    a.status = ST_DUPLICATE;
                    break;
                end
            end
            if (a.status == ST_OK && !hit)
                a.status = ST_FULL;
            if (a.status == ST_OK)
            begin
                sh_key[idx]  = op.key;
                sh_next[idx] = NULL_LNK;
                sh_prev[idx] = NULL_LNK;
                if (idx != home)
                begin
                    tail = home;
                    for (int s = 0; s < sz; s++)
                    begin
                        n = sh_next[tail];
                        if (n >= sz) break;
                        tail = n;
                    end
                    sh_next[tail] = idx;
                    sh_prev[idx]  = tail;
                end
                where = idx;
            end
        end
        else
        begin
            if (!chain_find(op.key, sz, where))
                a.status = ST_NOT_FOUND;
            else
            begin
                if (sh_next[where] < sz) sh_prev[sh_next[where]] = sh_prev[where];
                if (sh_prev[where] < sz) sh_next[sh_prev[where]] = sh_next[where];
                sh_key[where]  = KEY_EMPTY;
                sh_next[where] = NULL_LNK;
                sh_prev[where] = NULL_LNK;
            end
        end
        if (a.status != ST_OK) where = 0;
        a.slot = where[SLOT_W-1:0];
        return a;
    endfunction

    function automatic void queue_op(kind_t k, logic [31:0] key);
        op_t op;
        op.kind = k;
        op.key  = key;
        pending_ops.push_back(op);
    endfunction

    // keys that collide often at the current size
    function automatic logic [31:0] pick_key(int sz);
        int r;
        r = $urandom_range(0, 9);
        if (r < 5 && used_keys.size() > 0)
            return used_keys[$urandom_range(0, used_keys.size() - 1)];
        if (r < 8)
            return $urandom_range(0, 7) * sz + $urandom_range(0, 3);
        if (r == 8)
            return KEY_EMPTY;
        return $urandom;
    endfunction

    // empty falling-edge block; the driver is below
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                // transfer happened at the last rising edge
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cycles <= 0;
        else
            cycles <= cycles + 1;
    end

    // drive at falling edge, based on what the rising edge saw
    bit req_taken;
    always @(posedge clk)
        req_taken <= rst_n && req_ch.valid && req_ch.ready;

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                answers_due.push_back(table_apply(pending_ops.pop_front()));
                accepted++;
            end
            if (!req_ch.valid || req_taken)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 5) == 0)
                begin
                    src_gap = $urandom_range(0, 4);
                    req_ch.valid <= 1'b0;
                end
                else if (pending_ops.size() > 0)
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.kind  <= pending_ops[0].kind;
                    req_ch.key   <= pending_ops[0].key;
                end
                else
                    req_ch.valid <= 1'b0;
            end
            // sink side stall bursts
            if (snk_gap > 0)
            begin
                snk_gap--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                snk_gap = $urandom_range(0, 4);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            // a request taken this edge is predicted at the falling edge,
            // but its answer cannot come out in the same cycle
            if (answers_due.size() == 0)
            begin
                $error("response with nothing expected: status %0d slot %0d",
                       rsp_ch.status, rsp_ch.slot_index);
                failures++;
            end
            else
            begin
                want = answers_due.pop_front();
                checked++;
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d actual %0d", want.status, rsp_ch.status);
                    failures++;
                end
                if (rsp_ch.slot_index !== want.slot)
                begin
                    $error("slot_index: expected %0d actual %0d", want.slot,
                           rsp_ch.slot_index);
                    failures++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_ops.size() > 0 || req_ch.valid || req_taken ||
               answers_due.size() > 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);   // a clear may still be running
    endtask

    task automatic set_size(logic [10:0] v);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sh_size = v;
    endtask

    task automatic random_phase(int n, logic [10:0] sz_cfg);
        int sz, r;
        logic [31:0] k;
        set_size(sz_cfg);
        sz = eff_size();
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            k = pick_key(sz);
            if (k != KEY_EMPTY) used_keys.push_back(k);
            if (used_keys.size() > 64) void'(used_keys.pop_front());
            if (r < 45)      queue_op(KIND_INSERT, k);
            else if (r < 72) queue_op(KIND_LOOKUP, k);
            else if (r < 98) queue_op(KIND_REMOVE, k);
            else             queue_op(KIND_CLEAR, $urandom);
        end
        wait_drained();
    endtask

    initial
    begin
        failures = 0;
        accepted = 0;
        checked = 0;
        calm = 1'b0;
        src_gap = 0;
        snk_gap = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req_ch.valid = 1'b0;
        req_ch.kind = KIND_LOOKUP;
        req_ch.key = '0;
        rsp_ch.ready = 1'b0;
        sh_size = CFG_SIZE_RESET;
        wipe_table();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset size, extremes, reserved key, duplicates, clear
        queue_op(KIND_LOOKUP, 32'd0);
        queue_op(KIND_INSERT, 32'd0);
        queue_op(KIND_INSERT, 32'd0);
        queue_op(KIND_INSERT, 32'd1021);
        queue_op(KIND_INSERT, 32'hFFFF_FFFE);
        queue_op(KIND_LOOKUP, 32'd1021);
        queue_op(KIND_INSERT, KEY_EMPTY);
        queue_op(KIND_LOOKUP, KEY_EMPTY);
        queue_op(KIND_REMOVE, KEY_EMPTY);
        queue_op(KIND_REMOVE, 32'd0);
        queue_op(KIND_LOOKUP, 32'd1021);
        queue_op(KIND_REMOVE, 32'd5);
        queue_op(KIND_CLEAR, KEY_EMPTY);
        queue_op(KIND_LOOKUP, 32'hFFFF_FFFE);
        wait_drained();

        // size below range acts as 2: fill, then full table
        set_size(11'd0);
        queue_op(KIND_INSERT, 32'd4);
        queue_op(KIND_INSERT, 32'd6);
        queue_op(KIND_INSERT, 32'd8);
        queue_op(KIND_LOOKUP, 32'd6);
        queue_op(KIND_REMOVE, 32'd4);
        queue_op(KIND_LOOKUP, 32'd6);
        queue_op(KIND_CLEAR, 32'd0);
        wait_drained();

        random_phase(200, 11'd3);
        random_phase(200, 11'd7);
        random_phase(150, 11'd2047);
        random_phase(200, 11'd13);
        random_phase(150, 11'd1);
        random_phase(200, 11'd1024);
        random_phase(150, 11'd31);
        calm = 1'b1;
        random_phase(180, 11'd11);

        $display("covered %0d requests and %0d responses over sizes 0 to 2047,",
                 accepted, checked);
        $display("with chains, full tables, reserved keys and clears");
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

`default_nettype wire
